>>> hw/rtl/vlu_pkg.sv
package vlu_pkg;

	// Field and state widths
	localparam int BYTE_W = 8;
	localparam int DATA_W = 7;
	localparam int ACC_W  = 56;
	localparam int CNT_W  = 4;
	localparam int VAL_W  = 64;
	localparam int LEN_W  = 4;
	localparam int HALF_W = 32;

	// Output word: value, then length, padded to whole bytes
	localparam int M_TDATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - VAL_W - LEN_W;

	// Continuation flag position and per-mode continuation limits
	localparam int                CONT_BIT = 7;
	localparam logic [CNT_W-1:0]  LIMIT_32 = 4'd3;
	localparam logic [CNT_W-1:0]  LIMIT_64 = 4'd8;

	// Result of one decode step
	typedef struct packed {
		logic             emit;
		logic [ACC_W-1:0] acc_nxt;
		logic [CNT_W-1:0] cnt_nxt;
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] length;
	} vlu_step_t;

endpackage

>>> hw/rtl/vlu_step.sv
module vlu_step (
	input  logic                       wide_mode,
	input  logic [vlu_pkg::ACC_W-1:0]  acc,
	input  logic [vlu_pkg::CNT_W-1:0]  cnt,
	input  logic [vlu_pkg::BYTE_W-1:0] byte_in,
	output vlu_pkg::vlu_step_t         step
);
	import vlu_pkg::*;

	logic [CNT_W-1:0] limit;
	logic             below;
	logic             cont;
	logic [VAL_W-1:0] shifted;
	logic [VAL_W-1:0] merged;

	// Judge the byte against the limit of the current mode
	assign limit = wide_mode ? LIMIT_64 : LIMIT_32;
	assign below = (cnt < limit);
	assign cont  = below && byte_in[CONT_BIT];

	// Append the final byte: 7-bit shift below the limit, 8-bit shift at it
	assign shifted = below ? {1'b0, acc, {DATA_W{1'b0}}} : {acc, {BYTE_W{1'b0}}};
	assign merged  = shifted | {{(VAL_W-BYTE_W){1'b0}}, byte_in};

	always_comb begin
		step.emit   = !cont;
		step.length = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
		step.value  = merged;
		if (!wide_mode) begin
			step.value[VAL_W-1:HALF_W] = '0;
		end
		// Take a continuation group, or clear once the value ends
		if (cont) begin
			step.acc_nxt = {acc[ACC_W-DATA_W-1:0], byte_in[DATA_W-1:0]};
			step.cnt_nxt = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
		end else begin
			step.acc_nxt = '0;
			step.cnt_nxt = '0;
		end
	end

endmodule

>>> hw/rtl/vlu_integer_decoder_unit.sv
// Variable-length unsigned integer decoder, big-endian, 7 data bits per
// continuation byte.
// Input stream s_*: one encoded byte per word in s_tdata[7:0].
// Output stream m_*: one word per decoded value, value in m_tdata[63:0] and
// its byte length (1..9) in m_tdata[67:64]; the top bits are zero.
// Bytes with the continuation flag set below the limit produce no word.
// cfg_we/cfg_wdata set wide_mode: 0 = 32-bit form (up to 4 bytes),
// 1 = 64-bit form (up to 9 bytes). Write it only while the block is idle.
// A byte taken on s_* is held in the input register, and its result is loaded into the output register on m_*.
// Throughput: one byte per cycle unless a finished value meets a stalled output word;
// the decode is one shift-and-OR step between the input register and the output register.
// A stalled output word holds; the input register keeps draining
// continuation bytes and stalls only when a finished value would have to
// overwrite the waiting word.
// Reset clears the input register, the output word, the partial value and
// the mode (32-bit form).
module vlu_integer_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,  // wide_mode
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vlu_pkg::BYTE_W-1:0]    s_tdata,    // byte_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vlu_pkg::M_TDATA_W-1:0] m_tdata     // value[63:0], length[67:64]
);
	import vlu_pkg::*;

	logic              wide_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  value_q;
	logic [LEN_W-1:0]  length_q;
	logic              s1_adv;
	vlu_step_t         step;

	vlu_step u_step (
		.wide_mode (wide_q),
		.acc       (acc_q),
		.cnt       (cnt_q),
		.byte_in   (byte_s1),
		.step      (step)
	);

	// Advance the held byte unless it ends a value and the output is blocked
	assign s1_adv   = valid_s1 && (!step.emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			wide_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// Partial value and continuation count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (s1_adv) begin
			acc_q <= step.acc_nxt;
			cnt_q <= step.cnt_nxt;
		end
	end

	// Output word: load a finished value, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && step.emit) begin
			value_q  <= step.value;
			length_q <= step.length;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, length_q, value_q};

endmodule

>>> hw/rtl/vlu_checker.sv
module vlu_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [vlu_pkg::M_TDATA_W-1:0] m_tdata
);
	import vlu_pkg::*;

	logic [LEN_W-1:0] len;
	assign len = m_tdata[VAL_W +: LEN_W];

	// A stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// A stalled word keeps its contents
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	// Length stays within one to nine bytes, padding stays zero
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (len != '0) && (len <= 4'd9) && (m_tdata[M_TDATA_W-1:VAL_W+LEN_W] == '0))
		else $error("output length out of range");

	// A single-byte value fits in one byte
	a_len_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (len == 4'd1) |-> (m_tdata[VAL_W-1:BYTE_W] == '0))
		else $error("single-byte value too wide");

endmodule

bind vlu_integer_decoder_unit vlu_checker u_vlu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/vlu_integer_decoder_unit_test.sv
`timescale 1ns / 1ps

module vlu_integer_decoder_unit_test;

	import vlu_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_BYTES   = 135;
	localparam int unsigned MAX_REPORTS   = 10;

	// One decoded value with its byte length
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] length;
	} decoded_t;

	// Tracks the decode state and holds the values still owed by the block
	class vlu_scoreboard;
		bit               wide;
		bit [ACC_W-1:0]   acc;
		bit [CNT_W-1:0]   cnt;
		decoded_t         owed_q[$];
		int unsigned      bytes_seen;
		int unsigned      words_seen;
		int unsigned      errors;

		function void set_mode(input bit m);
			wide = m;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// Advance the decode by one accepted byte
		function void note_byte(input bit [BYTE_W-1:0] b);
			bit [CNT_W-1:0] lim;
			bit [VAL_W-1:0] v;
			decoded_t       d;
			lim = wide ? LIMIT_64 : LIMIT_32;
			bytes_seen++;
			if (cnt < lim && b[CONT_BIT]) begin
				acc = {acc[ACC_W-DATA_W-1:0], b[DATA_W-1:0]};
				cnt = cnt + 1'b1;
			end else begin
				v = {{(VAL_W-ACC_W){1'b0}}, acc};
				// Past the limit the last byte carries all 8 bits
				v = (cnt < lim) ? (v << DATA_W) : (v << BYTE_W);
				v = v | {{(VAL_W-BYTE_W){1'b0}}, b};
				if (!wide)
					v[VAL_W-1:HALF_W] = '0;
				d.value  = v;
				d.length = cnt + 1'b1;
				owed_q.push_back(d);
				acc = '0;
				cnt = '0;
			end
		endfunction

		// Compare one output word against the oldest owed value
		function void check_word(input logic [M_TDATA_W-1:0] word);
			decoded_t got;
			decoded_t want;
			got.value  = word[VAL_W-1:0];
			got.length = word[VAL_W +: LEN_W];
			words_seen++;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: unexpected word value=%h length=%0d",
						got.value, got.length);
				return;
			end
			want = owed_q.pop_front();
			if (got.value !== want.value || got.length !== want.length) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: word %0d expected value=%h length=%0d, got value=%h length=%0d",
						words_seen, want.value, want.length, got.value, got.length);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;     // byte_in
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;     // value[63:0], length[67:64]

	vlu_scoreboard sb;
	int unsigned   burst_left;
	int unsigned   mode_writes;
	int unsigned   stall_left;
	int unsigned   rx_tick;
	int unsigned   rx_mode;
	bit [7:0]      rx_pat = 8'b1011_0010;
	bit            hold_req;
	int unsigned   holds_done;

	vlu_integer_decoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check accepted words and drive the receiver's stall pattern
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata);
		rx_tick++;
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			stall_left = HOLD_CYCLES;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (rx_tick % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: begin
					rx_pat = {rx_pat[6:0], rx_pat[7]};
					m_tready <= rx_pat[0];
				end
			endcase
		end
	end

	// Watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ERROR: timeout after %0d cycles", cycles);
		$display("*** FAILED ***");
		$finish;
	end

	// Offer one byte, hold until taken, then maybe pause before the next
	task automatic send_byte(input bit [BYTE_W-1:0] b);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_byte(b);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_mode(input bit m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		sb.set_mode(m);
		mode_writes++;
		cfg_we <= 1'b0;
	endtask

	// Let every owed value come out, then give the input register time to empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic bit [DATA_W-1:0] group7();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return DATA_W'($urandom_range(0, 127));
		endcase
	endfunction

	// Send one well-formed encoded value for the current mode
	task automatic send_value();
		int unsigned lim;
		int unsigned n;
		lim = sb.wide ? LIMIT_64 : LIMIT_32;
		case ($urandom_range(0, 3))
			0: n = 1;
			1: n = lim + 1;
			default: n = $urandom_range(1, lim + 1);
		endcase
		repeat (n - 1) send_byte({1'b1, group7()});
		if (n - 1 == lim)
			send_byte(BYTE_W'($urandom_range(0, 255)));
		else
			send_byte({1'b0, group7()});
	endtask

	initial begin
		bit          phase_mode [8];
		int unsigned target;
		int unsigned lim;
		phase_mode = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		sb = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Narrow form: smallest, one-byte max, two bytes, full four bytes
		write_mode(1'b0);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h81);
		send_byte(8'h00);
		repeat (4) send_byte(8'hFF);

		// Start narrow, switch to wide mid-value, finish at nine bytes
		send_byte(8'hFF);
		send_byte(8'hFF);
		drain();
		write_mode(1'b1);
		repeat (7) send_byte(8'hFF);

		// Start wide, switch to narrow past its limit: 8-bit shift, truncated
		repeat (5) send_byte(8'hFF);
		drain();
		write_mode(1'b0);
		send_byte(8'hFF);
		drain();

		// Random phases in both forms, sometimes leaving a partial value
		for (int p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			if (p == 2)
				hold_req = 1'b1;
			target = sb.bytes_seen + PHASE_BYTES;
			while (sb.bytes_seen < target) begin
				if ($urandom_range(0, 4) != 0)
					send_value();
				else
					send_byte(BYTE_W'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 1) != 0) begin
				lim = sb.wide ? LIMIT_64 : LIMIT_32;
				repeat ($urandom_range(1, lim)) send_byte({1'b1, group7()});
			end
			drain();
		end

		if (sb.pending() != 0) begin
			sb.errors++;
			$display("ERROR: %0d decoded values never arrived", sb.pending());
		end
		$display("Sent %0d bytes and checked %0d decoded words across %0d mode writes,",
			sb.bytes_seen, sb.words_seen, mode_writes);
		$display("covering both forms, mode switches inside partial values and %0d long stall(s).",
			holds_done);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
